// ===== src/dnsrsp_pkg.sv =====
// Package: shared types and constants for the DNS response snoop parser.
`default_nettype none
package dnsrsp_pkg;

    localparam int DNS_HEADER_BYTES = 12;
    localparam int UDP_HEADER_BYTES = 8;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_UDP    = 4'd1;
    localparam logic [3:0] PH_HDR    = 4'd2;
    localparam logic [3:0] PH_LBLLEN = 4'd3;
    localparam logic [3:0] PH_LABEL  = 4'd4;
    localparam logic [3:0] PH_QTAIL  = 4'd5;
    localparam logic [3:0] PH_AFIX   = 4'd6;
    localparam logic [3:0] PH_ADATA  = 4'd7;
    localparam logic [3:0] PH_RDLEN  = 4'd8;
    localparam logic [3:0] PH_RDATA  = 4'd9;
    localparam logic [3:0] PH_DONE   = 4'd10;

    localparam logic [2:0] K_CHAR  = 3'd0;
    localparam logic [2:0] K_END   = 3'd1;
    localparam logic [2:0] K_ADDR  = 3'd2;
    localparam logic [2:0] K_TRUNC = 3'd3;
    localparam logic [2:0] K_LONG  = 3'd4;
    localparam logic [2:0] K_FLAGS = 3'd5;
    localparam logic [2:0] K_SHORT = 3'd6;

    localparam logic [1:0] CFG_FLAGS_FIRST  = 2'd0;
    localparam logic [1:0] CFG_FLAGS_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_NAME     = 2'd2;

    localparam logic [15:0] TYPE_A = 16'd1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] result_value;
        logic        packet_done;
    } out_item_t;

    typedef struct packed {
        logic [15:0] flags_first;
        logic [15:0] flags_second;
        logic [7:0]  max_name;
    } cfg_t;

endpackage
`default_nettype wire

// ===== src/dnsrsp_parse.sv =====
// Front part: byte-wise protocol parser producing at most one result per byte.
`default_nettype none
module dnsrsp_parse
    import dnsrsp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      in_valid,
    input  wire in_item_t  in_item,
    output logic           res_valid,
    output out_item_t      res_item
);

    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  offset_reg, offset_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] hword_reg, hword_next;
    logic [15:0] qleft_reg, qleft_next;
    logic [15:0] aleft_reg, aleft_next;
    logic [7:0]  lleft_reg, lleft_next;
    logic [7:0]  nlen_reg, nlen_next;
    logic [15:0] rtype_reg, rtype_next;
    logic [15:0] dleft_reg, dleft_next;
    logic [31:0] addr_reg, addr_next;

    logic [7:0]  b;
    logic [3:0]  ph;
    logic [15:0] r;
    logic [15:0] hw;
    logic [15:0] ql, al, am1;
    logic [3:0]  off;
    logic [7:0]  nl;
    logic [8:0]  nsum;
    logic [16:0] bp1;
    logic        has_res, abort;
    logic [2:0]  kind;
    logic [31:0] value;
    logic        done;

    always_comb
    begin
        b = in_item.data_byte;
        phase_next = phase_reg;
        offset_next = offset_reg;
        remain_next = remain_reg;
        hword_next = hword_reg;
        qleft_next = qleft_reg;
        aleft_next = aleft_reg;
        lleft_next = lleft_reg;
        nlen_next = nlen_reg;
        rtype_next = rtype_reg;
        dleft_next = dleft_reg;
        addr_next = addr_reg;
        has_res = 1'b0;
        abort = 1'b0;
        kind = K_CHAR;
        value = '0;
        done = 1'b0;
        ph = phase_reg;
        off = offset_reg;
        r = remain_reg;
        hw = hword_reg;
        ql = qleft_reg;
        al = aleft_reg;
        nl = nlen_reg;
        if (in_item.first_byte)
        begin
            ph = PH_UDP;
            off = '0;
            r = '0;
            hw = '0;
            ql = '0;
            al = '0;
            nl = '0;
            phase_next = PH_UDP;
            offset_next = '0;
            remain_next = '0;
            hword_next = '0;
            qleft_next = '0;
            aleft_next = '0;
            lleft_next = '0;
            nlen_next = '0;
            rtype_next = '0;
            dleft_next = '0;
            addr_next = '0;
        end
        am1 = al - 16'd1;
        nsum = {1'b0, nl} + {1'b0, b} + 9'd1;
        bp1 = {9'd0, b} + 17'd1;
        if (ph != PH_IDLE && ph != PH_DONE)
        begin
            if (ph != PH_UDP)
                remain_next = (r == 16'd0) ? 16'd0 : r - 16'd1;
            unique case (ph)
                PH_UDP:
                begin
                    hword_next = {hw[7:0], b};
                    if (off == 4'd5)
                        remain_next = hword_next;
                    if (off >= 4'(UDP_HEADER_BYTES - 1))
                    begin
                        if (remain_next < 16'(UDP_HEADER_BYTES + DNS_HEADER_BYTES))
                        begin
                            has_res = 1'b1;
                            kind = K_SHORT;
                        end
                        else
                        begin
                            remain_next = remain_next - 16'(UDP_HEADER_BYTES);
                            phase_next = PH_HDR;
                            offset_next = '0;
                        end
                    end
                    else
                        offset_next = off + 4'd1;
                end
                PH_HDR:
                begin
                    hword_next = {hw[7:0], b};
                    if (off == 4'd3 && hword_next != cfg.flags_first
                        && hword_next != cfg.flags_second)
                    begin
                        has_res = 1'b1;
                        kind = K_FLAGS;
                    end
                    else
                    begin
                        if (off == 4'd5)
                            qleft_next = hword_next;
                        if (off == 4'd7)
                            aleft_next = hword_next;
                        if (off >= 4'(DNS_HEADER_BYTES - 1))
                        begin
                            offset_next = '0;
                            nlen_next = '0;
                            if (ql != 16'd0)
                                phase_next = PH_LBLLEN;
                            else if (aleft_next != 16'd0)
                                phase_next = PH_AFIX;
                            else
                                phase_next = PH_DONE;
                        end
                        else
                            offset_next = off + 4'd1;
                    end
                end
                PH_LBLLEN:
                begin
                    has_res = 1'b1;
                    if (b == 8'd0)
                    begin
                        if (r < 16'd5)
                            kind = K_TRUNC;
                        else
                        begin
                            kind = K_END;
                            phase_next = PH_QTAIL;
                            offset_next = '0;
                        end
                    end
                    else if (nsum >= {1'b0, cfg.max_name})
                        kind = K_LONG;
                    else if ({1'b0, r} < bp1)
                        kind = K_TRUNC;
                    else
                    begin
                        if (nl != 8'd0)
                        begin
                            kind = K_CHAR;
                            value = 32'h2E;
                        end
                        else
                            has_res = 1'b0;
                        nlen_next = nsum[7:0];
                        lleft_next = b;
                        phase_next = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    has_res = 1'b1;
                    kind = K_CHAR;
                    value = {24'd0, b};
                    lleft_next = lleft_reg - 8'd1;
                    if (lleft_next == 8'd0)
                        phase_next = PH_LBLLEN;
                end
                PH_QTAIL:
                begin
                    if (off >= 4'd3)
                    begin
                        qleft_next = ql - 16'd1;
                        offset_next = '0;
                        nlen_next = '0;
                        if (qleft_next != 16'd0)
                            phase_next = PH_LBLLEN;
                        else if (al != 16'd0)
                            phase_next = PH_AFIX;
                        else
                            phase_next = PH_DONE;
                    end
                    else
                        offset_next = off + 4'd1;
                end
                PH_AFIX:
                begin
                    if (off == 4'd0 && r < 16'd10)
                    begin
                        has_res = 1'b1;
                        kind = K_TRUNC;
                    end
                    else
                    begin
                        hword_next = {hw[7:0], b};
                        if (off == 4'd3)
                            rtype_next = hword_next;
                        if (off >= 4'd9)
                        begin
                            offset_next = '0;
                            phase_next = (rtype_reg == TYPE_A) ? PH_ADATA : PH_RDLEN;
                        end
                        else
                            offset_next = off + 4'd1;
                    end
                end
                PH_ADATA:
                begin
                    if (off == 4'd0 && r < 16'd6)
                    begin
                        has_res = 1'b1;
                        kind = K_TRUNC;
                    end
                    else
                    begin
                        if (off >= 4'd2)
                            addr_next = {addr_reg[23:0], b};
                        if (off >= 4'd5)
                        begin
                            has_res = 1'b1;
                            kind = K_ADDR;
                            value = addr_next;
                            offset_next = '0;
                            aleft_next = am1;
                            phase_next = (am1 == 16'd0) ? PH_DONE : PH_AFIX;
                            done = (am1 == 16'd0);
                        end
                        else
                            offset_next = off + 4'd1;
                    end
                end
                PH_RDLEN:
                begin
                    if (off == 4'd0)
                    begin
                        if (r < 16'd2)
                        begin
                            has_res = 1'b1;
                            kind = K_TRUNC;
                        end
                        else
                        begin
                            hword_next = {hw[7:0], b};
                            offset_next = 4'd1;
                        end
                    end
                    else
                    begin
                        hword_next = {hw[7:0], b};
                        dleft_next = hword_next;
                        if (remain_next < hword_next)
                        begin
                            has_res = 1'b1;
                            kind = K_TRUNC;
                        end
                        else if (hword_next == 16'd0)
                        begin
                            offset_next = '0;
                            aleft_next = am1;
                            phase_next = (am1 == 16'd0) ? PH_DONE : PH_AFIX;
                        end
                        else
                            phase_next = PH_RDATA;
                    end
                end
                PH_RDATA:
                begin
                    dleft_next = dleft_reg - 16'd1;
                    if (dleft_next == 16'd0)
                    begin
                        offset_next = '0;
                        aleft_next = am1;
                        phase_next = (am1 == 16'd0) ? PH_DONE : PH_AFIX;
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
            abort = has_res && (kind == K_TRUNC || kind == K_LONG
                || kind == K_FLAGS || kind == K_SHORT);
            if (ph > PH_DONE)
                has_res = 1'b0;
            else if (abort)
            begin
                value = '0;
                done = 1'b1;
                phase_next = PH_DONE;
            end
            else if (in_item.last_byte && phase_next != PH_DONE)
            begin
                has_res = 1'b1;
                kind = K_TRUNC;
                value = '0;
                done = 1'b1;
                phase_next = PH_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            offset_reg <= '0;
            remain_reg <= '0;
            hword_reg <= '0;
            qleft_reg <= '0;
            aleft_reg <= '0;
            lleft_reg <= '0;
            nlen_reg <= '0;
            rtype_reg <= '0;
            dleft_reg <= '0;
            addr_reg <= '0;
            res_valid <= 1'b0;
        end
        else
        begin
            res_valid <= in_valid && has_res;
            if (in_valid)
            begin
                phase_reg <= phase_next;
                offset_reg <= offset_next;
                remain_reg <= remain_next;
                hword_reg <= hword_next;
                qleft_reg <= qleft_next;
                aleft_reg <= aleft_next;
                lleft_reg <= lleft_next;
                nlen_reg <= nlen_next;
                rtype_reg <= rtype_next;
                dleft_reg <= dleft_next;
                addr_reg <= addr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_item.result_kind <= kind;
        res_item.result_value <= value;
        res_item.packet_done <= done;
    end

    a_done_on_abort: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.result_kind >= K_TRUNC |-> res_item.packet_done)
        else $error("abort result without packet_done");
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_DONE)
        else $error("phase out of range");
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.packet_done |-> phase_reg == PH_DONE)
        else $error("packet_done but parser still active");

endmodule
`default_nettype wire

// ===== src/dnsrsp_queue.sv =====
// Back part: result queue with credit-based full toward the parser.
`default_nettype none
module dnsrsp_queue
    import dnsrsp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire out_item_t wr_item,
    input  wire logic      in_push,
    output logic           full,
    output logic           empty,
    input  wire logic      pop,
    output out_item_t      rd_item
);

    out_item_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wptr_reg, rptr_reg;
    logic [QUEUE_AW:0]       count_reg, count_next;
    logic                    pend_reg;
    logic                    do_pop;

    assign empty = (count_reg == '0);
    assign do_pop = pop && !empty;
    assign rd_item = mem_reg[rptr_reg];
    // one in-flight request may still land, so reserve a slot for it
    assign full = ({1'b0, count_reg} + {{QUEUE_AW + 1{1'b0}}, pend_reg})
        >= (QUEUE_AW + 2)'(QUEUE_DEPTH);

    always_comb
    begin
        count_next = count_reg + (QUEUE_AW + 1)'(wr_en) - (QUEUE_AW + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= in_push && !full;
            count_reg <= count_next;
            if (wr_en)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wptr_reg] <= wr_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> count_reg < (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("result queue overflow");
    a_wr_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> pend_reg)
        else $error("write without accepted request");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("count out of range");

endmodule
`default_nettype wire

// ===== src/dns_response_snoop_parser.sv =====
// Top level: DNS response snoop parser with configuration registers.
// Takes one datagram byte per cycle while full is low, starting at the UDP header, and yields
// at most one result per byte (name characters, name ends, A addresses, abort codes). A request
// is accepted in any cycle while full is low; its result is registered in the parser and then
// written into the queue. Full is set by the occupancy of the four-entry result queue, so bytes
// stream back to back as long as results are popped. Configuration writes are always ready.
`default_nettype none
module dns_response_snoop_parser
    import dnsrsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire in_item_t   in_data,
    output logic            empty,
    input  wire logic       pop,
    output out_item_t       out_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      acc;
    logic      res_valid;
    out_item_t res_item;

    assign cfg_ready = 1'b1;
    assign acc = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flags_first <= 16'h8180;
            cfg_reg.flags_second <= 16'h8580;
            cfg_reg.max_name <= 8'd128;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FLAGS_FIRST:  cfg_reg.flags_first <= cfg_data;
                CFG_FLAGS_SECOND: cfg_reg.flags_second <= cfg_data;
                CFG_MAX_NAME:     cfg_reg.max_name <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    dnsrsp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (acc),
        .in_item   (in_data),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    dnsrsp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_item (res_item),
        .in_push (push),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .rd_item (out_data)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the DNS response snoop parser: byte streams, predicted results, config phases.
`timescale 1ns / 1ps
module tb_top
    import dnsrsp_pkg::*;
;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    in_item_t in_data = '0;
    logic empty;
    logic pop = 1'b0;
    out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    dns_response_snoop_parser uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
        .empty(empty), .pop(pop), .out_data(out_data), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    in_item_t byte_queue[$];
    out_item_t parse_results[$];
    int errors = 0;
    int idle_cycles = 0;
    bit send_idle_ok = 1'b1;
    bit recv_idle_ok = 1'b1;
    int hold_off = 0;

    // predictor state
    logic [15:0] flags_a, flags_b;
    logic [7:0] name_max;
    logic [3:0] phase;
    logic [3:0] offs;
    logic [15:0] rem_len, hword, q_left, a_left, rtype, d_left;
    logic [7:0] lbl_left, name_len;
    logic [31:0] addr_acc;

    task automatic clear_parse();
        phase = PH_IDLE; offs = '0; rem_len = '0; hword = '0; q_left = '0; a_left = '0;
        lbl_left = '0; name_len = '0; rtype = '0; d_left = '0; addr_acc = '0;
    endtask

    task automatic next_section();
        offs = '0;
        name_len = '0;
        if (q_left != 0) phase = PH_LBLLEN;
        else if (a_left != 0) phase = PH_AFIX;
        else phase = PH_DONE;
    endtask

    task automatic end_record();
        offs = '0;
        a_left = a_left - 16'd1;
        phase = (a_left == 0) ? PH_DONE : PH_AFIX;
    endtask

    task automatic predict_byte(input in_item_t it);
        logic [7:0] b;
        logic [15:0] r;
        bit got, done, abort;
        logic [2:0] kind;
        logic [31:0] val;
        out_item_t res;
        b = it.data_byte;
        got = 0; done = 0; abort = 0; kind = K_CHAR; val = '0;
        if (it.first_byte)
        begin
            clear_parse();
            phase = PH_UDP;
        end
        if (phase == PH_IDLE || phase == PH_DONE) return;
        r = rem_len;
        if (phase != PH_UDP) rem_len = (r == 0) ? 16'd0 : r - 16'd1;
        case (phase)
            PH_UDP:
            begin
                hword = {hword[7:0], b};
                if (offs == 5) rem_len = hword;
                if (offs >= UDP_HEADER_BYTES - 1)
                begin
                    if (rem_len < UDP_HEADER_BYTES + DNS_HEADER_BYTES)
                    begin
                        got = 1; kind = K_SHORT; abort = 1;
                    end
                    else
                    begin
                        rem_len = rem_len - 16'(UDP_HEADER_BYTES);
                        phase = PH_HDR;
                        offs = '0;
                    end
                end
                else offs++;
            end
            PH_HDR:
            begin
                hword = {hword[7:0], b};
                if (offs == 3 && hword != flags_a && hword != flags_b)
                begin
                    got = 1; kind = K_FLAGS; abort = 1;
                end
                else
                begin
                    if (offs == 5) q_left = hword;
                    if (offs == 7) a_left = hword;
                    if (offs >= DNS_HEADER_BYTES - 1) next_section();
                    else offs++;
                end
            end
            PH_LBLLEN:
            begin
                if (b == 0)
                begin
                    got = 1;
                    if (r < 5)
                    begin
                        kind = K_TRUNC; abort = 1;
                    end
                    else
                    begin
                        kind = K_END; phase = PH_QTAIL; offs = '0;
                    end
                end
                else if (32'(name_len) + 32'(b) + 1 >= 32'(name_max))
                begin
                    got = 1; kind = K_LONG; abort = 1;
                end
                else if (32'(r) < 32'(b) + 1)
                begin
                    got = 1; kind = K_TRUNC; abort = 1;
                end
                else
                begin
                    if (name_len != 0)
                    begin
                        got = 1; kind = K_CHAR; val = 32'h2E;
                    end
                    name_len = name_len + b + 8'd1;
                    lbl_left = b;
                    phase = PH_LABEL;
                end
            end
            PH_LABEL:
            begin
                got = 1; kind = K_CHAR; val = {24'd0, b};
                lbl_left = lbl_left - 8'd1;
                if (lbl_left == 0) phase = PH_LBLLEN;
            end
            PH_QTAIL:
            begin
                if (offs >= 3)
                begin
                    q_left = q_left - 16'd1;
                    next_section();
                end
                else offs++;
            end
            PH_AFIX:
            begin
                if (offs == 0 && r < 10)
                begin
                    got = 1; kind = K_TRUNC; abort = 1;
                end
                else
                begin
                    hword = {hword[7:0], b};
                    if (offs == 3) rtype = hword;
                    if (offs >= 9)
                    begin
                        offs = '0;
                        phase = (rtype == TYPE_A) ? PH_ADATA : PH_RDLEN;
                    end
                    else offs++;
                end
            end
            PH_ADATA:
            begin
                if (offs == 0 && r < 6)
                begin
                    got = 1; kind = K_TRUNC; abort = 1;
                end
                else
                begin
                    if (offs >= 2) addr_acc = {addr_acc[23:0], b};
                    if (offs >= 5)
                    begin
                        got = 1; kind = K_ADDR; val = addr_acc;
                        end_record();
                        if (phase == PH_DONE) done = 1;
                    end
                    else offs++;
                end
            end
            PH_RDLEN:
            begin
                if (offs == 0)
                begin
                    if (r < 2)
                    begin
                        got = 1; kind = K_TRUNC; abort = 1;
                    end
                    else
                    begin
                        hword = {hword[7:0], b};
                        offs = 4'd1;
                    end
                end
                else
                begin
                    hword = {hword[7:0], b};
                    d_left = hword;
                    if (rem_len < d_left)
                    begin
                        got = 1; kind = K_TRUNC; abort = 1;
                    end
                    else if (d_left == 0) end_record();
                    else phase = PH_RDATA;
                end
            end
            PH_RDATA:
            begin
                d_left = d_left - 16'd1;
                if (d_left == 0) end_record();
            end
            default:
            begin
                phase = PH_DONE;
                return;
            end
        endcase
        if (abort)
        begin
            val = '0; done = 1; phase = PH_DONE;
        end
        else if (it.last_byte && phase != PH_DONE)
        begin
            got = 1; kind = K_TRUNC; val = '0; done = 1; phase = PH_DONE;
        end
        if (got)
        begin
            res.result_kind = kind;
            res.result_value = val;
            res.packet_done = done;
            parse_results.push_back(res);
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("error at %0t: %s got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (push && !full)
            predict_byte(in_data);
        if (!(push && full))
        begin
            if (byte_queue.size() != 0 && !(send_idle_ok && $urandom_range(99) < 8))
            begin
                push <= 1'b1;
                in_data <= byte_queue.pop_front();
            end
            else
                push <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t want;
        if (pop && !empty)
        begin
            if (parse_results.size() == 0)
                report("unexpected result kind", 32'(out_data.result_kind), 32'd0);
            else
            begin
                want = parse_results.pop_front();
                if (out_data.result_kind !== want.result_kind)
                    report("result_kind", 32'(out_data.result_kind),
                           32'(want.result_kind));
                if (out_data.result_value !== want.result_value)
                    report("result_value", out_data.result_value, want.result_value);
                if (out_data.packet_done !== want.packet_done)
                    report("packet_done", 32'(out_data.packet_done),
                           32'(want.packet_done));
            end
        end
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            pop <= 1'b0;
        end
        else
            pop <= !(recv_idle_ok && $urandom_range(99) < 8);
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("dns_response_snoop_parser: mismatch");
            $finish;
        end
    end

    function automatic in_item_t mk(input logic [7:0] b, input bit f, input bit l);
        in_item_t it;
        it.data_byte = b;
        it.first_byte = f;
        it.last_byte = l;
        return it;
    endfunction

    // push a UDP+DNS datagram; n_q questions, answer records; corrupt controls breakage
    task automatic add_packet(input int n_q, input int n_a, input logic [15:0] flags,
                              input int corrupt);
        logic [7:0] bytes[$];
        int udp_len, n_lab, lab, nb, i, cut;
        logic [15:0] rl;
        for (i = 0; i < 12; i++) bytes.push_back(8'($urandom));
        bytes[2] = flags[15:8]; bytes[3] = flags[7:0];
        bytes[4] = 8'd0; bytes[5] = 8'(n_q); bytes[6] = 8'd0; bytes[7] = 8'(n_a);
        for (int q = 0; q < n_q; q++)
        begin
            n_lab = $urandom_range(1, 3);
            for (int k = 0; k < n_lab; k++)
            begin
                lab = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
                bytes.push_back(8'(lab));
                for (i = 0; i < lab; i++) bytes.push_back(8'($urandom));
            end
            bytes.push_back(8'd0);
            for (i = 0; i < 4; i++) bytes.push_back(8'($urandom));
        end
        for (int a = 0; a < n_a; a++)
        begin
            bytes.push_back(8'hC0); bytes.push_back(8'($urandom));
            bytes.push_back(8'd0);
            bytes.push_back(($urandom_range(2) != 0) ? 8'd1 : 8'($urandom));
            for (i = 0; i < 6; i++) bytes.push_back(8'($urandom));
            if (bytes[bytes.size() - 7] == 1 && bytes[bytes.size() - 8] == 0)
            begin
                for (i = 0; i < 6; i++) bytes.push_back(8'($urandom));
            end
            else
            begin
                rl = 16'($urandom_range(0, 5));
                bytes.push_back(8'd0); bytes.push_back(rl[7:0]);
                for (i = 0; i < rl; i++) bytes.push_back(8'($urandom));
            end
        end
        udp_len = bytes.size() + 8;
        if (corrupt == 1) udp_len = $urandom_range(0, 19);
        if (corrupt == 2) udp_len = udp_len - $urandom_range(1, 10);
        if (corrupt == 3) udp_len = $urandom;
        cut = 8 + bytes.size();
        if (corrupt == 4) cut = $urandom_range(1, cut);
        nb = 0;
        for (i = 0; i < cut; i++)
        begin
            logic [7:0] v;
            if (i < 8)
                v = (i == 4) ? 8'(udp_len >> 8) : (i == 5) ? 8'(udp_len) : 8'($urandom);
            else
                v = bytes[i - 8];
            byte_queue.push_back(mk(v, i == 0, i == cut - 1));
        end
    endtask

    task automatic drain(input int settle);
        wait (byte_queue.size() == 0);
        @(posedge clk);
        while (push || parse_results.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FLAGS_FIRST: flags_a = val;
            CFG_FLAGS_SECOND: flags_b = val;
            default: name_max = val[7:0];
        endcase
    endtask

    function automatic logic [15:0] pick_flags();
        return $urandom_range(1) ? flags_a : flags_b;
    endfunction

    initial
    begin
        flags_a = 16'h8180; flags_b = 16'h8580; name_max = 8'd128;
        clear_parse();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed
        add_packet(1, 1, 16'h8180, 0);
        add_packet(2, 2, 16'h8580, 0);
        add_packet(1, 0, 16'h1234, 0);
        add_packet(0, 1, 16'h8180, 1);
        byte_queue.push_back(mk(8'hFF, 1'b0, 1'b1));
        byte_queue.push_back(mk(8'h00, 1'b0, 1'b0));
        add_packet(1, 1, 16'h8180, 4);
        drain(10);
        write_reg(CFG_FLAGS_FIRST, 16'hFFFF);
        write_reg(CFG_FLAGS_SECOND, 16'h0000);
        write_reg(CFG_MAX_NAME, 16'd2);
        add_packet(1, 1, 16'hFFFF, 0);
        add_packet(1, 1, 16'h0000, 0);
        drain(10);
        write_reg(CFG_MAX_NAME, 16'd255);
        add_packet(2, 1, 16'hFFFF, 0);
        // receiver holds off while bytes keep coming
        hold_off = 300;
        add_packet(3, 3, 16'h0000, 0);
        drain(10);
        write_reg(CFG_FLAGS_FIRST, 16'h8180);
        write_reg(CFG_FLAGS_SECOND, 16'h8580);
        write_reg(CFG_MAX_NAME, 16'd20);
        for (int p = 0; p < 3; p++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                int c;
                c = $urandom_range(9);
                add_packet($urandom_range(0, 2), $urandom_range(0, 3),
                           (c == 0) ? 16'($urandom) : pick_flags(), (c < 6) ? 0 : c - 5);
            end
            if (p == 1)
            begin
                send_idle_ok = 0;
                recv_idle_ok = 0;
            end
            else
            begin
                send_idle_ok = 1;
                recv_idle_ok = 1;
            end
            drain(10);
            write_reg(CFG_MAX_NAME, 16'($urandom_range(30, 200)));
            write_reg(CFG_FLAGS_SECOND, 16'($urandom));
        end
        drain(20);
        if (errors == 0)
            $display("dns_response_snoop_parser: match");
        else
            $display("dns_response_snoop_parser: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/dnsrsp_pkg.sv
src/dnsrsp_parse.sv
src/dnsrsp_queue.sv
src/dns_response_snoop_parser.sv
tb/sv/tb_top.sv
